/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ddd_pkg.sv */
`timescale 1ns / 1ps

package ddd_pkg;

  // Field widths of the date and result fields.
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 22;
  // Day numbers of shifted years up to 16783 fit in 23 bits.
  localparam int DNUM_W  = 23;

  // Largest count that the result field can carry; larger ones saturate.
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Smallest day number of a valid date: January 1 of year zero, which falls in
  // shifted year 399 because January and February count with the year before.
  localparam logic [DNUM_W-1:0] DNUM_MIN = DNUM_W'(365 * 399 + 99 - 3 + 0 + 306 + 1);

  // Edges from an accepted transaction to the edge that takes its result.
  localparam int PIPE_LAT = 5;

  // One input transaction: two dates.
  typedef struct packed {
    logic [DAY_W-1:0]   first_day;
    logic [MONTH_W-1:0] first_month;
    logic [YEAR_W-1:0]  first_year;
    logic [DAY_W-1:0]   second_day;
    logic [MONTH_W-1:0] second_month;
    logic [YEAR_W-1:0]  second_year;
  } in_t;

  // One result transaction.
  typedef struct packed {
    logic               dates_ok;
    logic [COUNT_W-1:0] day_count;
  } out_t;

  // A single date as fed to a day-number pipeline.
  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  // Status and day number leaving a day-number pipeline.
  typedef struct packed {
    logic              vld;
    logic              ok;
    logic [DNUM_W-1:0] num;
  } date_info_t;

endpackage

/* rtl/ddd_day_number.sv */
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ddd_day_number
  import ddd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       date_vld,
  input  date_t      date_in,
  output date_info_t info_out
);

  // Days from March 1 to the first of the month (year starts in March).
  function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [8:0] off;
    case (m)
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      4'd0:    off = 9'd275;
      4'd1:    off = 9'd306;
      4'd13:   off = 9'd306;
      4'd2:    off = 9'd337;
      4'd14:   off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

  // Month length for every month but February; zero for a bad month.
  function automatic logic [DAY_W-1:0] base_length(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  localparam logic [YEAR_W:0] YEAR_SHIFT = 15'd400;
  localparam logic [12:0]     RECIP_100  = 13'd5243;

  logic [3:0] vld_r;

  // Stage 1: year quotient by 100, shifted year, month lookups.
  logic [YEAR_W-1:0]  s1_year_r;
  logic [7:0]         s1_qy_r;
  logic [YEAR_W:0]    s1_yy_r;
  logic [8:0]         s1_moff_r;
  logic [DAY_W-1:0]   s1_len_r;
  logic               s1_feb_r;
  logic [DAY_W-1:0]   s1_day_r;

  logic [26:0]        qy_prod;
  logic [YEAR_W:0]    yy_nxt;

  assign qy_prod = date_in.year * RECIP_100;
  assign yy_nxt  = {1'b0, date_in.year} + YEAR_SHIFT
                   - ((date_in.month <= 4'd2) ? 15'd1 : 15'd0);

  always_ff @(posedge clk) begin
    s1_year_r <= date_in.year;
    s1_qy_r   <= qy_prod[26:19];
    s1_yy_r   <= yy_nxt;
    s1_moff_r <= month_offset(date_in.month);
    s1_len_r  <= base_length(date_in.month);
    s1_feb_r  <= (date_in.month == 4'd2);
    s1_day_r  <= date_in.day;
  end

  // Stage 2: leap rule and date check; shifted-year quotient by 100.
  logic [13:0]       rem_prod;
  logic [YEAR_W-1:0] rem100;
  logic              div100;
  logic              leap;
  logic [DAY_W-1:0]  mlen;
  logic [27:0]       qyy_prod;

  assign rem_prod = 14'(s1_qy_r) * 14'd100;
  assign rem100   = s1_year_r - rem_prod;
  assign div100   = (rem100 == '0);
  assign leap     = ((s1_year_r[1:0] == 2'd0) && !div100) || (div100 && s1_qy_r[1:0] == 2'd0);
  assign mlen     = s1_feb_r ? (leap ? 5'd29 : 5'd28) : s1_len_r;
  assign qyy_prod = s1_yy_r * RECIP_100;

  logic              s2_ok_r;
  logic [YEAR_W:0]   s2_yy_r;
  logic [7:0]        s2_qyy_r;
  logic [8:0]        s2_moff_r;
  logic [DAY_W-1:0]  s2_day_r;

  always_ff @(posedge clk) begin
    s2_ok_r   <= (mlen != '0) && (s1_day_r != '0) && (s1_day_r <= mlen);
    s2_yy_r   <= s1_yy_r;
    s2_qyy_r  <= qyy_prod[26:19];
    s2_moff_r <= s1_moff_r;
    s2_day_r  <= s1_day_r;
  end

  // Stage 3: whole years in days, and the small correction terms.
  logic [23:0] yr_days;
  logic [12:0] small_sum;

  assign yr_days   = s2_yy_r * 9'd365;
  assign small_sum = s2_yy_r[YEAR_W:2] - 13'(s2_qyy_r) + 13'(s2_qyy_r[7:2])
                     + 13'(s2_moff_r) + 13'(s2_day_r);

  logic              s3_ok_r;
  logic [DNUM_W-1:0] s3_years_r;
  logic [12:0]       s3_small_r;

  always_ff @(posedge clk) begin
    s3_ok_r    <= s2_ok_r;
    s3_years_r <= yr_days[DNUM_W-1:0];
    s3_small_r <= small_sum;
  end

  // Stage 4: final day number.
  logic              s4_ok_r;
  logic [DNUM_W-1:0] s4_num_r;

  always_ff @(posedge clk) begin
    s4_ok_r  <= s3_ok_r;
    s4_num_r <= s3_years_r + DNUM_W'(s3_small_r);
  end

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], date_vld};
    end
  end

  assign info_out.vld = vld_r[3];
  assign info_out.ok  = s4_ok_r;
  assign info_out.num = s4_num_r;

  // A valid date never lies before January 1 of year zero.
  `ASSERT_IMPLIES(a_num_floor, clk, rst_n, info_out.vld && info_out.ok, info_out.num >= DNUM_MIN, "day number below the smallest valid date")

  // Every date offered enters the valid chain on the next edge.
  `ASSERT_NEXT(a_vld_enter, clk, rst_n, date_vld, vld_r[0], "offered date lost from the valid chain")

  // Every valid day number comes from a date that passed through the whole valid chain.
  `ASSERT_IMPLIES(a_vld_source, clk, rst_n, info_out.vld, $past(date_vld, 4), "day number without a matching date")

endmodule

/* rtl/date_difference_in_days_unit.sv */
`timescale 1ns / 1ps

// Gregorian date difference unit.
// Input channel: a transaction is taken at a rising edge with start high and
// busy low. Each transaction carries two dates (day, month, year) in in_data.
// busy is always low: the unit takes one date pair in every cycle.
// Result channel: out_valid is high for exactly one cycle with out_data, which
// holds whether both dates are valid and the absolute day count between them.
// The count is 0 when either date is invalid and saturates at 4194303.
// One result per transaction, in order, shown on out_valid once the
// transaction has passed through every stage. Throughput is one transaction
// per cycle, set by a four-stage day-number pipeline per date and one stage
// for the difference and saturation.
// The receiver cannot hold results off, so nothing ever stalls.
// Reset (rst_n low, synchronous) clears every valid bit; transactions in
// flight are dropped and no result appears until new ones are taken.

`include "assert_macros.svh"

module date_difference_in_days_unit
  import ddd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  logic       accept;
  date_t      date_a;
  date_t      date_b;
  date_info_t info_a;
  date_info_t info_b;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign date_a = '{day: in_data.first_day, month: in_data.first_month,
                    year: in_data.first_year};
  assign date_b = '{day: in_data.second_day, month: in_data.second_month,
                    year: in_data.second_year};

  // One day-number pipeline per date.
  ddd_day_number u_num_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .date_vld (accept),
    .date_in  (date_a),
    .info_out (info_a)
  );

  ddd_day_number u_num_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .date_vld (accept),
    .date_in  (date_b),
    .info_out (info_b)
  );

  // Absolute difference with saturation.
  logic              both_ok;
  logic [DNUM_W-1:0] diff_ab;
  logic [DNUM_W-1:0] diff_ba;
  logic [DNUM_W-1:0] mag;
  logic [COUNT_W-1:0] count_nxt;

  assign both_ok   = info_a.ok && info_b.ok;
  assign diff_ab   = info_a.num - info_b.num;
  assign diff_ba   = info_b.num - info_a.num;
  assign mag       = (info_a.num >= info_b.num) ? diff_ab : diff_ba;
  assign count_nxt = !both_ok ? '0 : (mag[DNUM_W-1] ? COUNT_MAX : mag[COUNT_W-1:0]);

  logic out_valid_r;
  out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= info_a.vld && info_b.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.dates_ok  <= both_ok;
    out_data_r.day_count <= count_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Every result comes from a transaction that the unit took.
  `ASSERT_IMPLIES(a_out_source, clk, rst_n, out_valid, $past(accept, PIPE_LAT), "result without a matching transaction")

  // An invalid date pair always reports a zero count.
  `ASSERT_IMPLIES(a_bad_zero, clk, rst_n, out_valid && !out_data.dates_ok, out_data.day_count == '0, "nonzero count for invalid dates")

  // The unit never refuses a transaction.
  `ASSERT_NEXT(a_never_busy, clk, rst_n, 1'b1, !busy, "busy raised")

endmodule

/* tb/tb_date_difference_in_days_unit.sv */
`timescale 1ns / 1ps

module tb_date_difference_in_days_unit;
  import ddd_pkg::*;

  // Predicts the day count of each date pair and checks the results in order.
  class day_count_board;
    out_t        pending_spans[$];
    int unsigned fails;

    function new();
      fails = 0;
    endfunction

    static function bit is_leap(int unsigned yr);
      return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    static function int unsigned month_days(int unsigned mo, int unsigned yr);
      case (mo)
        1, 3, 5, 7, 8, 10, 12: return 31;
        4, 6, 9, 11: return 30;
        2: return is_leap(yr) ? 29 : 28;
        default: return 0;
      endcase
    endfunction

    static function bit date_valid(int unsigned dy, int unsigned mo, int unsigned yr);
      int unsigned len;
      len = month_days(mo, yr);
      return (len != 0) && (dy >= 1) && (dy <= len);
    endfunction

    // Day ordinal counted from a March-based year; the year offset of 400
    // keeps everything positive and cancels in the difference.
    static function int unsigned ordinal(int unsigned dy, int unsigned mo,
                                         int unsigned yr);
      int unsigned yy;
      int unsigned mp;
      yy = yr + 400 - ((mo <= 2) ? 1 : 0);
      mp = (mo + 9) % 12;
      return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mp + 2) / 5 + dy;
    endfunction

    function out_t predict_span(in_t p);
      out_t        r;
      int unsigned n1;
      int unsigned n2;
      int unsigned diff;
      r.dates_ok = date_valid(p.first_day, p.first_month, p.first_year) &&
                   date_valid(p.second_day, p.second_month, p.second_year);
      r.day_count = '0;
      if (r.dates_ok) begin
        n1 = ordinal(p.first_day, p.first_month, p.first_year);
        n2 = ordinal(p.second_day, p.second_month, p.second_year);
        diff = (n1 > n2) ? n1 - n2 : n2 - n1;
        r.day_count = (diff > COUNT_MAX) ? COUNT_MAX : COUNT_W'(diff);
      end
      return r;
    endfunction

    function void note_pair(in_t p);
      pending_spans.push_back(predict_span(p));
    endfunction

    function void check_span(out_t got);
      out_t want;
      if (pending_spans.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected result: ok=%0b count=%0d", got.dates_ok, got.day_count);
        return;
      end
      want = pending_spans.pop_front();
      if (got.dates_ok !== want.dates_ok || got.day_count !== want.day_count) begin
        fails++;
        if (fails <= 10)
          $display("day count mismatch: expected ok=%0b count=%0d, got ok=%0b count=%0d",
                   want.dates_ok, want.day_count, got.dates_ok, got.day_count);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  day_count_board board = new();
  bit             allow_gaps;

  date_difference_in_days_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Every result strobe is a transaction that must match the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      board.check_span(out_data);
  end

  // Offers one date pair, with an optional idle burst first, and waits until
  // the block takes it. Starts and ends on a falling edge.
  task automatic drive_pair(input in_t p);
    int gap;
    if (allow_gaps && $urandom_range(3) == 0) begin
      gap = $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (busy !== 1'b0);
    board.note_pair(p);
    @(negedge clk);
  endtask

  task automatic send_dates(input int unsigned d1, input int unsigned m1,
                            input int unsigned y1, input int unsigned d2,
                            input int unsigned m2, input int unsigned y2);
    in_t p;
    p.first_day    = DAY_W'(d1);
    p.first_month  = MONTH_W'(m1);
    p.first_year   = YEAR_W'(y1);
    p.second_day   = DAY_W'(d2);
    p.second_month = MONTH_W'(m2);
    p.second_year  = YEAR_W'(y2);
    drive_pair(p);
  endtask

  // Mostly well-formed dates, biased toward month ends, century years and
  // years past 9999; a wild date uses raw field values.
  task automatic random_date(input bit wild, output logic [DAY_W-1:0] dy,
                             output logic [MONTH_W-1:0] mo,
                             output logic [YEAR_W-1:0] yr);
    int unsigned pick;
    int unsigned len;
    if (wild) begin
      dy = DAY_W'($urandom);
      mo = MONTH_W'($urandom);
      yr = YEAR_W'($urandom);
    end else begin
      pick = $urandom_range(99);
      if (pick < 10)
        yr = YEAR_W'($urandom_range(99) * 100);
      else if (pick < 25)
        yr = YEAR_W'($urandom_range(16383, 10000));
      else
        yr = YEAR_W'($urandom_range(9999));
      mo  = MONTH_W'($urandom_range(1, 12));
      len = day_count_board::month_days(mo, yr);
      pick = $urandom_range(99);
      if (pick < 70)
        dy = DAY_W'($urandom_range(1, len));
      else if (pick < 85)
        dy = DAY_W'(len);
      else if (pick < 95)
        dy = DAY_W'(len + 1);
      else
        dy = DAY_W'($urandom_range(1));
    end
  endtask

  task automatic send_random_pair();
    in_t         p;
    int unsigned mode;
    mode = $urandom_range(99);
    random_date(mode < 10 || (mode >= 10 && mode < 15),
                p.first_day, p.first_month, p.first_year);
    random_date(mode < 10 || (mode >= 15 && mode < 20),
                p.second_day, p.second_month, p.second_year);
    // A share of equal dates.
    if (mode >= 20 && mode < 25) begin
      p.second_day   = p.first_day;
      p.second_month = p.first_month;
      p.second_year  = p.first_year;
    end
    drive_pair(p);
  endtask

  initial begin
    int unsigned wait_cycles;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    allow_gaps = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed cases: ordering, leap rules, invalid fields and extremes.
    send_dates(1, 1, 2000, 1, 1, 2000);
    send_dates(31, 12, 1999, 1, 1, 2000);
    send_dates(1, 1, 2000, 31, 12, 1999);
    send_dates(29, 2, 2000, 1, 3, 2000);
    send_dates(29, 2, 1900, 1, 1, 1900);
    send_dates(29, 2, 2024, 28, 2, 2023);
    send_dates(29, 2, 2023, 1, 1, 2023);
    send_dates(30, 2, 2000, 1, 1, 2000);
    send_dates(31, 4, 2021, 1, 4, 2021);
    send_dates(30, 4, 2021, 31, 5, 2021);
    send_dates(0, 1, 2000, 1, 1, 2000);
    send_dates(1, 0, 2000, 1, 1, 2000);
    send_dates(1, 1, 2000, 1, 13, 2000);
    send_dates(15, 7, 2000, 1, 14, 2000);
    send_dates(31, 15, 16383, 1, 1, 0);
    send_dates(0, 0, 0, 0, 0, 0);
    send_dates(29, 2, 0, 1, 1, 0);
    send_dates(1, 1, 0, 31, 12, 9999);
    send_dates(31, 12, 16383, 1, 1, 0);
    send_dates(31, 12, 16383, 31, 12, 16383);
    send_dates(1, 1, 10000, 1, 1, 9999);
    send_dates(1, 1, 1, 31, 12, 1);
    send_dates(31, 1, 2001, 1, 2, 2001);

    // Random pairs; the tail runs back to back.
    for (int i = 0; i < 2000; i++) begin
      allow_gaps = (i < 1700);
      send_random_pair();
    end
    start <= 1'b0;

    // Drain the pipeline, then keep watching for strays.
    wait_cycles = 0;
    while (board.pending_spans.size() != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (board.pending_spans.size() != 0) begin
      $display("[FAIL] regression broken");
    end else begin
      repeat (PIPE_LAT + 4) @(posedge clk);
      if (board.fails == 0 && board.pending_spans.size() == 0) begin
        $display("[ OK ] regression clean");
      end else begin
        $display("[FAIL] regression broken");
      end
    end
    $finish;
  end

endmodule
